// ===== sv/humidity_temp_frame_decoder_defines.svh =====
// Assertion macros shared by the checker of the frame decoder.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/htfd_pkg.sv =====
// Types, constants and the CRC function of the measurement frame decoder.
package htfd_pkg;

  // CRC-8 settings of the sensor frame.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Status byte bit positions.
  localparam int STAT_BUSY_BIT   = 7;
  localparam int STAT_CRC_EN_BIT = 4;
  localparam int STAT_CAL_BIT    = 3;

  // Byte positions of the status byte and of the CRC byte, the last of the seven.
  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_LAST  = 3'd6;

  // Result codes.
  localparam logic [1:0] RC_OK    = 2'd0;
  localparam logic [1:0] RC_BUSY  = 2'd1;
  localparam logic [1:0] RC_CRC   = 2'd2;
  localparam logic [1:0] RC_NOCAL = 2'd3;

  // Scaling constants for the fixed-point conversions.
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  // Field offsets in the result tdata, lowest bit up.
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_RH_LSB     = 8;
  localparam int OUT_RT_LSB     = 28;
  localparam int OUT_HC_LSB     = 48;
  localparam int OUT_TC_LSB     = 62;
  localparam int OUT_DATA_W     = 80;

  // One complete frame handed from the assembler to the converter.
  typedef struct packed {
    logic [7:0]  status;
    logic [39:0] payload;
    logic        crc_match;
  } frame_t;

  // One decoded result.
  typedef struct packed {
    logic [1:0]         code;
    logic [7:0]         status;
    logic [19:0]        raw_hum;
    logic [19:0]        raw_temp;
    logic [13:0]        hum_centi;
    logic signed [14:0] temp_centi;
  } result_t;

  // CRC-8 over one byte, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/htfd_frame_asm.sv =====
// Frame assembler: byte position, running CRC and payload capture.
module htfd_frame_asm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  output logic              frm_valid,
  input  logic              frm_ready,
  output htfd_pkg::frame_t  frm
);

  logic [2:0]       pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [39:0]      payload_r, payload_nxt;
  logic             frm_valid_r, frm_valid_nxt;
  htfd_pkg::frame_t frm_r, frm_nxt;
  logic [2:0]       pos_eff;
  logic             take;

  // A byte is taken whenever the frame register is free or being drained.
  assign byte_ready = !frm_valid_r || frm_ready;
  assign take       = byte_valid && byte_ready;

  // A start flag or an impossible position restarts the frame.
  assign pos_eff = (frame_start || (pos_r > htfd_pkg::POS_LAST)) ? htfd_pkg::POS_FIRST : pos_r;

  // Next-state logic for the frame being collected.
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    status_nxt    = status_r;
    payload_nxt   = payload_r;
    frm_nxt       = frm_r;
    frm_valid_nxt = frm_valid_r && !frm_ready;
    if (take) begin
      if (pos_eff == htfd_pkg::POS_FIRST) begin
        status_nxt  = rx_byte;
        payload_nxt = '0;
        crc_nxt     = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, rx_byte);
        pos_nxt     = 3'd1;
      end else if (pos_eff < htfd_pkg::POS_LAST) begin
        payload_nxt = {payload_r[31:0], rx_byte};
        crc_nxt     = htfd_pkg::crc8_byte(crc_r, rx_byte);
        pos_nxt     = pos_eff + 3'd1;
      end else begin
        frm_nxt.status    = status_r;
        frm_nxt.payload   = payload_r;
        frm_nxt.crc_match = (crc_r == rx_byte);
        frm_valid_nxt     = 1'b1;
        crc_nxt           = htfd_pkg::CRC_INIT;
        pos_nxt           = htfd_pkg::POS_FIRST;
      end
    end
  end

  // Control state and the bytes being collected are reset; the frame register is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= htfd_pkg::POS_FIRST;
      crc_r       <= htfd_pkg::CRC_INIT;
      status_r    <= '0;
      payload_r   <= '0;
      frm_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      status_r    <= status_nxt;
      payload_r   <= payload_nxt;
      frm_valid_r <= frm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
  end

  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

endmodule

// ===== sv/htfd_convert.sv =====
// Result stage: status check, raw value split and fixed-point scaling.
module htfd_convert (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frm_valid,
  output logic              frm_ready,
  input  htfd_pkg::frame_t  frm,
  output logic              res_valid,
  input  logic              res_ready,
  output htfd_pkg::result_t res
);

  logic              res_valid_r;
  htfd_pkg::result_t res_r, res_nxt;
  logic [19:0]       rh;
  logic [19:0]       rt;
  logic [33:0]       hum_prod;
  logic [34:0]       temp_prod;
  logic [14:0]       temp_scaled;
  logic [1:0]        code;

  // The result register takes a frame when it is empty or being read out.
  assign frm_ready = !res_valid_r || res_ready;

  // Status checks in priority order: busy, checksum, calibration.
  always_comb begin
    if (frm.status[htfd_pkg::STAT_BUSY_BIT]) begin
      code = htfd_pkg::RC_BUSY;
    end else if (!frm.crc_match || !frm.status[htfd_pkg::STAT_CRC_EN_BIT]) begin
      code = htfd_pkg::RC_CRC;
    end else if (!frm.status[htfd_pkg::STAT_CAL_BIT]) begin
      code = htfd_pkg::RC_NOCAL;
    end else begin
      code = htfd_pkg::RC_OK;
    end
  end

  // Scaling by 10000 and 20000 over 2^20, floored by dropping the low bits.
  assign rh          = frm.payload[39:20];
  assign rt          = frm.payload[19:0];
  assign hum_prod    = 34'(rh) * 34'(htfd_pkg::HUM_SCALE);
  assign temp_prod   = 35'(rt) * 35'(htfd_pkg::TEMP_SCALE);
  assign temp_scaled = temp_prod[34:20];

  // Error codes carry the status byte only.
  always_comb begin
    res_nxt.code   = code;
    res_nxt.status = frm.status;
    if (code == htfd_pkg::RC_OK) begin
      res_nxt.raw_hum    = rh;
      res_nxt.raw_temp   = rt;
      res_nxt.hum_centi  = hum_prod[33:20];
      res_nxt.temp_centi = $signed(temp_scaled - htfd_pkg::TEMP_OFFSET);
    end else begin
      res_nxt.raw_hum    = '0;
      res_nxt.raw_temp   = '0;
      res_nxt.hum_centi  = '0;
      res_nxt.temp_centi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (frm_ready) begin
      res_valid_r <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_valid && frm_ready) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== sv/humidity_temp_frame_decoder.sv =====
// Top level of the humidity and temperature measurement frame decoder.
// The block takes one frame byte per cycle on the input stream and gives one
// result per seven-byte frame. The running CRC-8 is updated for a whole byte in
// a single cycle, so bytes are accepted back to back for as long as the result
// side keeps up. After its CRC byte is accepted, a frame is held in the frame
// register and then in the result register, which takes the products of the
// hundredths scaling. A set start flag (in_tuser) drops any partial frame and
// takes its byte as the status byte; without it, frames simply follow each
// other every seven bytes.
module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] status_byte, [27:8] raw_humidity, [47:28] raw_temperature,
  // [61:48] humidity_centi, [76:62] temperature_centi, [79:77] zero
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] result_code
);

  logic              frm_valid;
  logic              frm_ready;
  htfd_pkg::frame_t  frm;
  htfd_pkg::result_t res;

  // Byte collection and CRC.
  htfd_frame_asm u_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_tvalid),
    .byte_ready  (in_tready),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser[0]),
    .frm_valid   (frm_valid),
    .frm_ready   (frm_ready),
    .frm         (frm)
  );

  // Checks, scaling and the output register.
  htfd_convert u_cnv (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {3'b000, res.temp_centi, res.hum_centi, res.raw_temp,
                      res.raw_hum, res.status};
  assign out_tuser = res.code;

endmodule

// ===== sv/htfd_checker.sv =====
// Port-level checker for the frame decoder, bound to the top level.
`include "humidity_temp_frame_decoder_defines.svh"

module htfd_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds its value.
  `HTFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser),
    "result changed while stalled")

  // Any error code leaves every field but the status byte at zero.
  `HTFD_ASSERT_NOW(a_err_zero, clk, rst_n, out_tvalid && (out_tuser != htfd_pkg::RC_OK),
    out_tdata[79:htfd_pkg::OUT_RH_LSB] == '0, "error result carries data")

  // A busy status always reports busy first.
  `HTFD_ASSERT_NOW(a_busy_first, clk, rst_n,
    out_tvalid && out_tdata[htfd_pkg::STAT_BUSY_BIT], out_tuser == htfd_pkg::RC_BUSY,
    "busy status not reported as busy")

  // A good result has a CRC-enabled, calibrated status and humidity below 100 percent.
  `HTFD_ASSERT_NOW(a_ok_status, clk, rst_n, out_tvalid && (out_tuser == htfd_pkg::RC_OK),
    out_tdata[htfd_pkg::STAT_CRC_EN_BIT] && out_tdata[htfd_pkg::STAT_CAL_BIT] &&
    (out_tdata[61:48] < htfd_pkg::HUM_SCALE), "good result with bad status or range")

endmodule

bind humidity_temp_frame_decoder htfd_port_checker u_htfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
